// ----- sv/lifo_stack_allocator_unit_macros.svh -----
// Assertion macros shared by the LIFO stack allocator checker
`ifndef LIFO_STACK_ALLOCATOR_UNIT_MACROS_SVH
`define LIFO_STACK_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the clock, quiet during reset
`define LSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the clock, quiet during reset
`define LSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/lsa_pkg.sv -----
// Types, sizes and codes of the LIFO stack allocator
`default_nettype none

package lsa_pkg;

    // Sizing
    localparam int STACK_DEPTH = 16;
    localparam int OFFSET_BITS = 16;
    localparam int WORD_W      = 16;
    localparam int LIM_W       = 5;
    localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W       = (CNT_W > LIM_W) ? CNT_W : LIM_W;

    localparam logic [CMP_W-1:0]  DEPTH_CMP   = CMP_W'(STACK_DEPTH);
    localparam logic [WORD_W-1:0] CAP_RESET   = 16'hFFFF;
    localparam logic [LIM_W-1:0]  LIMIT_RESET = 5'd16;
    localparam logic [WORD_W-1:0] OFF_MASK    = (OFFSET_BITS >= WORD_W) ? 16'hFFFF :
                                                16'((32'd1 << OFFSET_BITS) - 32'd1);

    // Request kinds; code 3 is unused and falls to the default arm
    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_RESET = 2'd2
    } t_action;

    // Result codes
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_ZERO   = 3'd1,
        ST_NOROOM = 3'd2,
        ST_FULL   = 3'd3,
        ST_EMPTY  = 3'd4
    } t_status;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_ARENA_CAPACITY = 1'b0,
        REG_STACK_LIMIT    = 1'b1
    } t_cfg_reg;

    // Controller states
    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;  // capture the request beat and start the stack read
        logic exec;   // evaluate the request and commit state and result
    } t_dp_cmd;

endpackage

`default_nettype wire

// ----- sv/lifo_stack_allocator_unit.sv -----
// LIFO stack allocator: top level
//
// A request beat is taken when start is high and busy is low. Every request
// takes two cycles: one to capture it and read the top of the size stack
// RAM, whose registered read sets this figure, and one to check and commit.
// The result beat then shows on the o_ outputs with o_done high for exactly
// one cycle and cannot be held off; a new request may be taken in that same
// cycle, so requests run at one every two cycles. o_bytes_in_use is valid
// with o_done. Configuration writes take effect at once and belong in idle
// time only.
`default_nettype none

module lifo_stack_allocator_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cfg_we,
    input  wire logic [0:0]                    i_cfg_idx,
    input  wire logic [lsa_pkg::WORD_W-1:0]    i_cfg_wdata,
    input  wire logic [1:0]                    i_action,
    input  wire logic [lsa_pkg::WORD_W-1:0]    i_request_bytes,
    output logic                               o_done,
    output logic [2:0]                         o_status,
    output logic [lsa_pkg::WORD_W-1:0]         o_block_offset,
    output logic [lsa_pkg::WORD_W-1:0]         o_freed_bytes,
    output logic [lsa_pkg::WORD_W-1:0]         o_bytes_in_use
);

    lsa_pkg::t_dp_cmd cmd;

    // Sequencer
    lsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // Arena datapath
    lsa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_action        (i_action),
        .i_request_bytes (i_request_bytes),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_block_offset  (o_block_offset),
        .o_freed_bytes   (o_freed_bytes),
        .o_bytes_in_use  (o_bytes_in_use)
    );

endmodule

`default_nettype wire

// ----- sv/lsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module lsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/lsa_ctrl.sv -----
// Controller state machine of the LIFO stack allocator
`default_nettype none

module lsa_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    output lsa_pkg::t_dp_cmd      o_cmd
);

    lsa_pkg::t_state r_state;
    lsa_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsa_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = lsa_pkg::S_EXEC;
                end
            end
            lsa_pkg::S_EXEC: begin
                n_state = lsa_pkg::S_IDLE;
            end
            default: begin
                n_state = lsa_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_busy = 1'b0;
        o_cmd  = '0;
        case (r_state)
            lsa_pkg::S_IDLE: begin
                o_cmd.latch = i_start;
            end
            lsa_pkg::S_EXEC: begin
                o_busy     = 1'b1;
                o_cmd.exec = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/lsa_dp.sv -----
// Datapath: config registers, use counters, size stack and result registers
`default_nettype none

module lsa_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  lsa_pkg::t_dp_cmd                   i_cmd,
    input  wire logic                          i_cfg_we,
    input  wire logic [0:0]                    i_cfg_idx,
    input  wire logic [lsa_pkg::WORD_W-1:0]    i_cfg_wdata,
    input  wire logic [1:0]                    i_action,
    input  wire logic [lsa_pkg::WORD_W-1:0]    i_request_bytes,
    output logic                               o_done,
    output logic [2:0]                         o_status,
    output logic [lsa_pkg::WORD_W-1:0]         o_block_offset,
    output logic [lsa_pkg::WORD_W-1:0]         o_freed_bytes,
    output logic [lsa_pkg::WORD_W-1:0]         o_bytes_in_use
);

    // Configuration
    logic [lsa_pkg::WORD_W-1:0] r_cap;
    logic [lsa_pkg::LIM_W-1:0]  r_limit;

    // Arena state
    logic [lsa_pkg::WORD_W-1:0] r_used;
    logic [lsa_pkg::WORD_W-1:0] n_used;
    logic [lsa_pkg::CNT_W-1:0]  r_count;
    logic [lsa_pkg::CNT_W-1:0]  n_count;

    // Latched request beat
    lsa_pkg::t_action           r_action;
    logic [lsa_pkg::WORD_W-1:0] r_req;

    // Result registers
    logic                       r_done;
    lsa_pkg::t_status           r_status;
    lsa_pkg::t_status           n_status;
    logic [lsa_pkg::WORD_W-1:0] r_offset;
    logic [lsa_pkg::WORD_W-1:0] n_offset;
    logic [lsa_pkg::WORD_W-1:0] r_freed;
    logic [lsa_pkg::WORD_W-1:0] n_freed;

    // Stack access
    logic                       push;
    logic [lsa_pkg::CNT_W-1:0]  count_dec;
    logic [lsa_pkg::PTR_W-1:0]  pop_addr;
    logic [lsa_pkg::WORD_W-1:0] top_size;
    logic [lsa_pkg::CMP_W-1:0]  lim_eff;
    logic                       room_fail;
    logic                       stack_full;

    // Configuration writes; unknown index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= lsa_pkg::CAP_RESET;
            r_limit <= lsa_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (lsa_pkg::t_cfg_reg'(i_cfg_idx))
                lsa_pkg::REG_ARENA_CAPACITY: r_cap   <= i_cfg_wdata;
                lsa_pkg::REG_STACK_LIMIT:    r_limit <= i_cfg_wdata[lsa_pkg::LIM_W-1:0];
                default: begin
                    r_cap <= r_cap;
                end
            endcase
        end
    end

    // Capture request beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= lsa_pkg::t_action'(i_action);
            r_req    <= i_request_bytes;
        end
    end

    // Top of stack address, read issued at accept so data is ready in execute
    assign count_dec = r_count - lsa_pkg::CNT_W'(1);
    assign pop_addr  = (r_count == '0) ? '0 : count_dec[lsa_pkg::PTR_W-1:0];

    lsa_ram #(
        .WIDTH (lsa_pkg::WORD_W),
        .DEPTH (lsa_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_count[lsa_pkg::PTR_W-1:0]),
        .i_wdata (r_req),
        .i_re    (i_cmd.latch),
        .i_raddr (pop_addr),
        .o_rdata (top_size)
    );

    // Checks: room without wrap, limit clamped to the depth
    assign room_fail  = ({1'b0, r_used} + {1'b0, r_req}) > {1'b0, r_cap};
    assign lim_eff    = (lsa_pkg::CMP_W'(r_limit) > lsa_pkg::DEPTH_CMP) ?
                        lsa_pkg::DEPTH_CMP : lsa_pkg::CMP_W'(r_limit);
    assign stack_full = lsa_pkg::CMP_W'(r_count) >= lim_eff;

    // Request evaluation
    always_comb begin
        n_used   = r_used;
        n_count  = r_count;
        n_status = lsa_pkg::ST_OK;
        n_offset = '0;
        n_freed  = '0;
        push     = 1'b0;
        case (r_action)
            lsa_pkg::ACT_ALLOC: begin
                if (r_req == '0) begin
                    n_status = lsa_pkg::ST_ZERO;
                end else if (room_fail) begin
                    n_status = lsa_pkg::ST_NOROOM;
                end else if (stack_full) begin
                    n_status = lsa_pkg::ST_FULL;
                end else begin
                    push     = i_cmd.exec;
                    n_count  = r_count + lsa_pkg::CNT_W'(1);
                    n_offset = r_used & lsa_pkg::OFF_MASK;
                    n_used   = r_used + r_req;
                end
            end
            lsa_pkg::ACT_FREE: begin
                if (r_count == '0) begin
                    n_status = lsa_pkg::ST_EMPTY;
                end else begin
                    n_count = count_dec;
                    n_freed = top_size;
                    n_used  = r_used - top_size;
                end
            end
            lsa_pkg::ACT_RESET: begin
                n_used  = '0;
                n_count = '0;
            end
            default: begin
                n_used = r_used;
            end
        endcase
    end

    // Arena state commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_used  <= n_used;
            r_count <= n_count;
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.exec;
        end
    end

    // Result beat payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_offset <= n_offset;
            r_freed  <= n_freed;
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_block_offset = r_offset;
    assign o_freed_bytes  = r_freed;
    assign o_bytes_in_use = r_used;

endmodule

`default_nettype wire

// ----- sv/lsa_chk.sv -----
// Port-level checker for the LIFO stack allocator, bound to the top level
`default_nettype none

`include "lifo_stack_allocator_unit_macros.svh"

module lsa_chk (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic                          o_done,
    input  wire logic [2:0]                    o_status,
    input  wire logic [lsa_pkg::WORD_W-1:0]    o_block_offset,
    input  wire logic [lsa_pkg::WORD_W-1:0]    o_freed_bytes
);

    logic accept;
    logic failed;

    assign accept = start && !busy;
    assign failed = o_done && (o_status != lsa_pkg::ST_OK);

    // An accepted beat holds off the next one for the execute cycle
    `LSA_ASSERT_NEXT(a_busy_after_accept, accept, busy, "busy low after accept")

    // Every accepted beat yields its result beat after the execute state
    `LSA_ASSERT_NOW(a_result_follows, accept, ##2 o_done, "result beat missing")

    // The result cycle is an idle cycle, ready for the next request
    `LSA_ASSERT_NOW(a_idle_on_result, o_done, !busy, "busy during result beat")

    // A rejected request hands out and releases nothing
    `LSA_ASSERT_NOW(a_fail_zero, failed,
        (o_block_offset == '0) && (o_freed_bytes == '0), "payload on failed request")

endmodule

bind lifo_stack_allocator_unit lsa_chk u_chk (.*);

`default_nettype wire

// ----- sim/lifo_stack_allocator_unit_tb.sv -----
// Self-checking testbench for the LIFO stack allocator unit
`default_nettype none

module lifo_stack_allocator_unit_tb;

    // Spare request code; the block treats it as a no-op that reports use
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        lsa_pkg::t_status status;
        logic [15:0]      offset;
        logic [15:0]      freed;
        logic [15:0]      in_use;
    } t_arena_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [15:0] i_cfg_wdata;
    logic [1:0]  i_action;
    logic [15:0] i_request_bytes;
    logic        o_done;
    logic [2:0]  o_status;
    logic [15:0] o_block_offset;
    logic [15:0] o_freed_bytes;
    logic [15:0] o_bytes_in_use;

    // Shadow of the allocator state and registers
    logic [15:0] cap_reg;
    logic [4:0]  limit_reg;
    logic [15:0] arena_used;
    int unsigned live_blocks;
    logic [15:0] block_sizes [lsa_pkg::STACK_DEPTH];

    t_arena_result pending_results [$];
    bit            idle_on;
    int unsigned   requests_sent;
    int unsigned   results_seen;
    int unsigned   mismatches;
    int unsigned   allocs_placed;
    int unsigned   blocks_freed;
    int unsigned   rejects;

    lifo_stack_allocator_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_action        (i_action),
        .i_request_bytes (i_request_bytes),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_block_offset  (o_block_offset),
        .o_freed_bytes   (o_freed_bytes),
        .o_bytes_in_use  (o_bytes_in_use)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Predict one request and advance the shadow state
    function automatic t_arena_result predict_request(input logic [1:0] act,
                                                      input logic [15:0] req);
        t_arena_result r;
        int unsigned   lim;
        r.status = lsa_pkg::ST_OK;
        r.offset = '0;
        r.freed  = '0;
        lim = (limit_reg > lsa_pkg::STACK_DEPTH) ? lsa_pkg::STACK_DEPTH : limit_reg;
        case (act)
            lsa_pkg::ACT_ALLOC: begin
                if (req == '0) begin
                    r.status = lsa_pkg::ST_ZERO;
                end else if (int'(arena_used) + int'(req) > int'(cap_reg)) begin
                    r.status = lsa_pkg::ST_NOROOM;
                end else if (live_blocks >= lim) begin
                    r.status = lsa_pkg::ST_FULL;
                end else begin
                    block_sizes[live_blocks % lsa_pkg::STACK_DEPTH] = req;
                    live_blocks++;
                    r.offset = arena_used & lsa_pkg::OFF_MASK;
                    arena_used = arena_used + req;
                    allocs_placed++;
                end
                if (r.status != lsa_pkg::ST_OK) rejects++;
            end
            lsa_pkg::ACT_FREE: begin
                if (live_blocks == 0) begin
                    r.status = lsa_pkg::ST_EMPTY;
                    rejects++;
                end else begin
                    live_blocks--;
                    r.freed = block_sizes[live_blocks % lsa_pkg::STACK_DEPTH];
                    arena_used = arena_used - r.freed;
                    blocks_freed++;
                end
            end
            lsa_pkg::ACT_RESET: begin
                arena_used  = '0;
                live_blocks = 0;
            end
            default: ;
        endcase
        r.in_use = (act == lsa_pkg::ACT_RESET) ? 16'd0 : arena_used;
        return r;
    endfunction

    // One request beat: hold it until taken, then log what it must return
    task automatic send_request(input logic [1:0] act, input logic [15:0] req);
        start           <= 1'b1;
        i_action        <= act;
        i_request_bytes <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(predict_request(act, req));
        requests_sent++;
        if (idle_on && $urandom_range(99) < 7) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Drain all results, then wait out the request pipe
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] cap_word, input logic [15:0] lim_word);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= lsa_pkg::REG_ARENA_CAPACITY;
        i_cfg_wdata <= cap_word;
        @(posedge i_clk);
        cap_reg = cap_word;
        i_cfg_idx   <= lsa_pkg::REG_STACK_LIMIT;
        i_cfg_wdata <= lim_word;
        @(posedge i_clk);
        limit_reg = lim_word[4:0];
        i_cfg_we <= 1'b0;
    endtask

    // Limit value with junk in the unused upper bits
    function automatic logic [15:0] limit_word(input logic [4:0] lim);
        logic [15:0] w;
        w      = 16'($urandom);
        w[4:0] = lim;
        return w;
    endfunction

    // Size biased toward the capacity edge and the stack filling up
    function automatic logic [15:0] pick_size();
        int unsigned room;
        int unsigned r;
        room = (cap_reg >= arena_used) ? int'(cap_reg) - int'(arena_used) : 0;
        r    = $urandom_range(99);
        if (r < 5)       return 16'd0;
        else if (r < 17) return 16'($urandom);
        else if (r < 30) return 16'(room);
        else if (r < 40) return 16'(room + 1);
        else             return 16'($urandom_range(1, (cap_reg >> 3) + 1));
    endfunction

    // Size extremes, empty free, no-wrap room test, spare code, arena reset
    task automatic test_edge_sizes();
        send_request(lsa_pkg::ACT_FREE,  16'($urandom));
        send_request(lsa_pkg::ACT_ALLOC, 16'd0);
        send_request(lsa_pkg::ACT_ALLOC, 16'd1);
        send_request(lsa_pkg::ACT_ALLOC, 16'd65534);
        send_request(lsa_pkg::ACT_ALLOC, 16'd1);
        send_request(lsa_pkg::ACT_FREE,  16'hFFFF);
        send_request(lsa_pkg::ACT_FREE,  16'd0);
        send_request(ACT_SPARE, 16'hFFFF);
        send_request(lsa_pkg::ACT_ALLOC, 16'hFFFF);
        send_request(lsa_pkg::ACT_ALLOC, 16'hFFFF);
        send_request(lsa_pkg::ACT_RESET, 16'hFFFF);
        send_request(ACT_SPARE, 16'd0);
    endtask

    // Small limit, zero limit, limit below count, capacity below use
    task automatic test_stack_limits();
        set_config(16'hFFFF, limit_word(5'd3));
        repeat (4) send_request(lsa_pkg::ACT_ALLOC, 16'd1);
        set_config(16'hFFFF, limit_word(5'd0));
        send_request(lsa_pkg::ACT_ALLOC, 16'd1);
        send_request(lsa_pkg::ACT_FREE, 16'd0);
        set_config(16'd0, limit_word(5'd1));
        send_request(lsa_pkg::ACT_ALLOC, 16'd1);
        repeat (3) send_request(lsa_pkg::ACT_FREE, 16'd0);
    endtask

    task automatic run_random_phase(input int unsigned n, input int unsigned alloc_pct);
        int unsigned r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < alloc_pct)
                send_request(lsa_pkg::ACT_ALLOC, pick_size());
            else if (r < 92)
                send_request(lsa_pkg::ACT_FREE, 16'($urandom));
            else if (r < 96)
                send_request(ACT_SPARE, 16'($urandom));
            else
                send_request(lsa_pkg::ACT_RESET, 16'($urandom));
        end
    endtask

    // Random traffic across capacity and limit settings, extremes included
    task automatic test_random_sweep();
        idle_on = 1'b0;
        set_config(16'hFFFF, limit_word(5'd16));
        run_random_phase(120, 60);
        idle_on = 1'b1;
        set_config(16'd1, limit_word(5'd16));
        run_random_phase(60, 55);
        set_config(16'd0, limit_word(5'd5));
        run_random_phase(40, 50);
        set_config(16'd100, limit_word(5'd0));
        run_random_phase(60, 55);
        set_config(16'hFFFF, limit_word(5'd31));
        run_random_phase(140, 65);
        set_config(16'd40000, limit_word(5'd17));
        run_random_phase(120, 60);
        set_config(16'($urandom_range(1, 65535)), limit_word(5'd1));
        run_random_phase(80, 55);
        set_config(16'($urandom_range(1, 65535)), limit_word(5'($urandom)));
        run_random_phase(100, 55);
        set_config(16'd300, limit_word(5'd8));
        run_random_phase(100, 58);
        set_config(16'hFFFF, limit_word(5'd16));
        run_random_phase(80, 50);
    endtask

    // Result check against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_arena_result want;
        if (i_rst_n && o_done) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status %0d offset %0d freed %0d in use %0d",
                             o_status, o_block_offset, o_freed_bytes, o_bytes_in_use);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_block_offset !== want.offset ||
                    o_freed_bytes !== want.freed || o_bytes_in_use !== want.in_use) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 results_seen, want.status, want.offset, want.freed,
                                 want.in_use, o_status, o_block_offset, o_freed_bytes,
                                 o_bytes_in_use);
                end
            end
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= lsa_pkg::REG_ARENA_CAPACITY;
        i_cfg_wdata     <= '0;
        i_action        <= lsa_pkg::ACT_ALLOC;
        i_request_bytes <= '0;
        cap_reg         = lsa_pkg::CAP_RESET;
        limit_reg       = lsa_pkg::LIMIT_RESET;
        arena_used      = '0;
        live_blocks     = 0;
        idle_on         = 1'b1;
        requests_sent   = 0;
        results_seen    = 0;
        mismatches      = 0;
        allocs_placed   = 0;
        blocks_freed    = 0;
        rejects         = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_sizes();
        test_stack_limits();
        test_random_sweep();
        wait_idle();

        $display("covered %0d requests and %0d result beats over many register settings",
                 requests_sent, results_seen);
        $display("  %0d blocks placed, %0d blocks freed, %0d requests rejected",
                 allocs_placed, blocks_freed, rejects);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("lifo_stack_allocator_unit_tb: PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("lifo_stack_allocator_unit_tb: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("lifo_stack_allocator_unit_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
